/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. Each check is disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define NCO_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication.
`define NCO_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* rtl/core/nco_pkg.sv */
// ----------------------------------------------------------------------------
// NCO package
// Shared types, constants and the elaboration-time sine table generator.
// ----------------------------------------------------------------------------
package nco_pkg;

    localparam int ROM_W  = 31;
    localparam int FRAC_W = 16;
    localparam int VAL_W  = 32;

    localparam logic [63:0] HALF_PI_Q60  = 64'h1921_FB54_442D_1847;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

    typedef enum logic {
        ST_FILL,
        ST_RUN
    } fill_state_t;

    typedef struct packed {
        logic load1;
        logic load2;
        logic load_out;
    } pipe_ctrl_t;

    // (a * b) >> 60, truncated to 64 bits
    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    // Unsigned quotient n / d by shift and subtract
    function automatic logic [63:0] div_u64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[63:0], n[i]};
            if (rem >= {1'b0, d})
            begin
                rem    = rem - {1'b0, d};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Taylor series sine, argument and result in unsigned Q60
    function automatic logic [63:0] sin_q60(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] k;
        logic        subtract;
        x2       = mul_q60(x, x);
        term     = x;
        sum      = x;
        k        = 64'd1;
        subtract = 1'b1;
        while (term != 64'd0 && k < 64'd60)
        begin
            term     = div_u64(mul_q60(term, x2), (k + 64'd1) * (k + 64'd2));
            sum      = subtract ? sum - term : sum + term;
            subtract = !subtract;
            k        = k + 64'd2;
        end
        return sum;
    endfunction

    // Quarter-wave table entry idx in Q30, rounded half up
    function automatic logic [ROM_W-1:0] sine_q30(input int sin_bits, input int idx);
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] i64;
        logic [63:0] x;
        logic [63:0] s;
        logic [63:0] t;
        q   = HALF_PI_Q60 >> sin_bits;
        r   = HALF_PI_Q60 & ((64'd1 << sin_bits) - 64'd1);
        i64 = 64'(idx);
        x   = q * i64 + ((r * i64) >> sin_bits);
        s   = sin_q60(x);
        t   = (s + 64'd536870912) >> 30;
        return t[ROM_W-1:0];
    endfunction

endpackage

/* rtl/core/nco_quadrature_sine_cosine.sv */
// ----------------------------------------------------------------------------
// Quadrature NCO
// Phase accumulator with quarter-wave sine table lookup and interpolation.
//
// Each request on the input channel (in_valid/in_ready, field restart) gives
// one cosine/sine pair in signed Q30 on the output channel (out_valid/
// out_ready), taken at the phase before the increment is added. restart
// clears the phase first. cfg_we/cfg_wdata write the phase increment; write
// it only while no request is in flight.
// Pipeline: the valid bit moves via v1_reg, v2_reg and vo_reg to out_valid.
// Throughput: one request per cycle while out_ready keeps the output moving,
// set by the registered table read and the one multiply per stage. Both
// table copies are read at two addresses per cycle.
// Reset: the phase and increment clear and the table memories are loaded by
// a fill pass that writes all 2^SIN_BITS+1 entries (257 at the default);
// in_ready stays low until it ends.
// Output stall: the result holds in the output register; earlier stages
// keep advancing into empty slots, so in_ready drops only when all are full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nco_quadrature_sine_cosine #(
    parameter int SIN_BITS = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [31:0]                        cfg_wdata,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               restart,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [nco_pkg::VAL_W-1:0]   cosine_value,
    output logic signed [nco_pkg::VAL_W-1:0]   sine_value
);

    localparam int SIN_SIZE = 1 << SIN_BITS;
    localparam int DEPTH    = SIN_SIZE + 1;
    localparam int AW       = $clog2(DEPTH);

    function automatic logic [DEPTH-1:0][nco_pkg::ROM_W-1:0] build_table();
        logic [DEPTH-1:0][nco_pkg::ROM_W-1:0] tab;
        for (int i = 0; i < DEPTH; i++)
        begin
            tab[i] = nco_pkg::sine_q30(SIN_BITS, i);
        end
        return tab;
    endfunction

    localparam logic [DEPTH-1:0][nco_pkg::ROM_W-1:0] SINE_TABLE = build_table();

    // control state
    nco_pkg::fill_state_t  state_reg;
    nco_pkg::fill_state_t  state_next;
    logic [AW-1:0]         fill_addr_reg;
    logic [AW-1:0]         fill_addr_next;
    logic                  fill_we;
    logic                  run;

    logic [31:0]           incr_reg;
    logic [31:0]           phase_reg;
    logic [31:0]           phase_next;

    logic                  v1_reg;
    logic                  v1_next;
    logic                  v2_reg;
    logic                  v2_next;
    logic                  vo_reg;
    logic                  vo_next;

    logic                  adv1;
    logic                  adv2;
    logic                  adv_o;
    logic                  accept;
    nco_pkg::pipe_ctrl_t   ctrl;

    // lookup address generation
    logic [31:0]                 cur_phase;
    logic [31:0]                 cos_phase;
    logic [SIN_BITS-1:0]         idx;
    logic [nco_pkg::FRAC_W-1:0]  frac;
    logic [AW-1:0]               even_a;
    logic [AW-1:0]               even_b;
    logic [AW-1:0]               odd_a;
    logic [AW-1:0]               odd_b;
    logic [AW-1:0]               sin_addr_a;
    logic [AW-1:0]               sin_addr_b;
    logic [AW-1:0]               cos_addr_a;
    logic [AW-1:0]               cos_addr_b;
    logic [nco_pkg::ROM_W-1:0]   fill_data;

    logic [nco_pkg::ROM_W-1:0]   sin_rdata_a;
    logic [nco_pkg::ROM_W-1:0]   sin_rdata_b;
    logic [nco_pkg::ROM_W-1:0]   cos_rdata_a;
    logic [nco_pkg::ROM_W-1:0]   cos_rdata_b;

    // ---------------- fill sequencer ----------------
    always_comb
    begin
        case (state_reg)
            nco_pkg::ST_FILL:
            begin
                if (fill_addr_reg == AW'(SIN_SIZE))
                begin
                    state_next = nco_pkg::ST_RUN;
                end
                else
                begin
                    state_next = nco_pkg::ST_FILL;
                end
            end
            nco_pkg::ST_RUN:
            begin
                state_next = nco_pkg::ST_RUN;
            end
            default:
            begin
                state_next = nco_pkg::ST_FILL;
            end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            nco_pkg::ST_FILL:
            begin
                fill_we = 1'b1;
                run     = 1'b0;
            end
            nco_pkg::ST_RUN:
            begin
                fill_we = 1'b0;
                run     = 1'b1;
            end
            default:
            begin
                fill_we = 1'b0;
                run     = 1'b0;
            end
        endcase
    end

    assign fill_addr_next = fill_we ? fill_addr_reg + AW'(1) : fill_addr_reg;
    assign fill_data      = SINE_TABLE[fill_addr_reg];

    // ---------------- pipeline flow control ----------------
    always_comb
    begin
        adv_o         = !vo_reg || out_ready;
        adv2          = !v2_reg || adv_o;
        adv1          = !v1_reg || adv2;
        in_ready      = run && adv1;
        accept        = in_valid && in_ready;
        ctrl.load1    = adv1;
        ctrl.load2    = adv2;
        ctrl.load_out = adv_o;
        v1_next       = adv1 ? accept : v1_reg;
        v2_next       = adv2 ? v1_reg : v2_reg;
        vo_next       = adv_o ? v2_reg : vo_reg;
    end

    // ---------------- phase and addresses ----------------
    always_comb
    begin
        cur_phase  = restart ? 32'd0 : phase_reg;
        phase_next = accept ? cur_phase + incr_reg : phase_reg;
        cos_phase  = cur_phase + nco_pkg::QUARTER_TURN;
        // index and fraction are shared: a quarter turn only moves the quadrant
        idx        = cur_phase[29 -: SIN_BITS];
        frac       = cur_phase[29 - SIN_BITS -: nco_pkg::FRAC_W];
        even_a     = {1'b0, idx};
        even_b     = even_a + AW'(1);
        // mirrored: SIN_SIZE - idx - 1 and SIN_SIZE - idx
        odd_b      = {1'b0, ~idx};
        odd_a      = odd_b + AW'(1);
        sin_addr_a = cur_phase[30] ? odd_a : even_a;
        sin_addr_b = cur_phase[30] ? odd_b : even_b;
        cos_addr_a = cos_phase[30] ? odd_a : even_a;
        cos_addr_b = cos_phase[30] ? odd_b : even_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nco_pkg::ST_FILL;
            fill_addr_reg <= '0;
            incr_reg      <= '0;
            phase_reg     <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            vo_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_addr_reg <= fill_addr_next;
            if (cfg_we)
            begin
                incr_reg <= cfg_wdata;
            end
            phase_reg     <= phase_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            vo_reg        <= vo_next;
        end
    end

    // ---------------- table memories ----------------
    nco_ram #(
        .WIDTH (nco_pkg::ROM_W),
        .DEPTH (DEPTH)
    ) u_sin_ram (
        .clk     (clk),
        .we      (fill_we),
        .waddr   (fill_addr_reg),
        .wdata   (fill_data),
        .re      (adv1),
        .raddr_a (sin_addr_a),
        .raddr_b (sin_addr_b),
        .rdata_a (sin_rdata_a),
        .rdata_b (sin_rdata_b)
    );

    nco_ram #(
        .WIDTH (nco_pkg::ROM_W),
        .DEPTH (DEPTH)
    ) u_cos_ram (
        .clk     (clk),
        .we      (fill_we),
        .waddr   (fill_addr_reg),
        .wdata   (fill_data),
        .re      (adv1),
        .raddr_a (cos_addr_a),
        .raddr_b (cos_addr_b),
        .rdata_a (cos_rdata_a),
        .rdata_b (cos_rdata_b)
    );

    // ---------------- interpolation ----------------
    nco_interp u_sin_interp (
        .clk     (clk),
        .ctrl    (ctrl),
        .rdata_a (sin_rdata_a),
        .rdata_b (sin_rdata_b),
        .frac    (frac),
        .negate  (cur_phase[31]),
        .value   (sine_value)
    );

    nco_interp u_cos_interp (
        .clk     (clk),
        .ctrl    (ctrl),
        .rdata_a (cos_rdata_a),
        .rdata_b (cos_rdata_b),
        .frac    (frac),
        .negate  (cos_phase[31]),
        .value   (cosine_value)
    );

    assign out_valid = vo_reg;

    // ---------------- assertions ----------------
    `NCO_ASSERT_IMP(a_no_req_in_fill, clk, rst_n, in_valid && in_ready, state_reg == nco_pkg::ST_RUN)
    `NCO_ASSERT_NXT(a_phase_advance, clk, rst_n, in_valid && in_ready && !restart, phase_reg == $past(phase_reg + incr_reg))
    `NCO_ASSERT_NXT(a_phase_restart, clk, rst_n, in_valid && in_ready && restart, phase_reg == $past(incr_reg))
    `NCO_ASSERT_NXT(a_stage2_holds, clk, rst_n, v2_reg && vo_reg && !out_ready, v2_reg && vo_reg)

endmodule

/* rtl/core/nco_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, two read ports, read data registered under a read enable.
// ----------------------------------------------------------------------------
module nco_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 257
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  logic [WIDTH-1:0]           wdata,
    input  logic                       re,
    input  logic [$clog2(DEPTH)-1:0]   raddr_a,
    input  logic [$clog2(DEPTH)-1:0]   raddr_b,
    output logic [WIDTH-1:0]           rdata_a,
    output logic [WIDTH-1:0]           rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a_reg <= mem_reg[raddr_a];
            rdata_b_reg <= mem_reg[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

/* rtl/core/nco_interp.sv */
// ----------------------------------------------------------------------------
// NCO interpolator
// Linear interpolation between two table entries and quadrant sign, registered in stage 1, stage 2 and output.
// ----------------------------------------------------------------------------
module nco_interp (
    input  logic                                clk,
    input  nco_pkg::pipe_ctrl_t                 ctrl,
    input  logic [nco_pkg::ROM_W-1:0]           rdata_a,
    input  logic [nco_pkg::ROM_W-1:0]           rdata_b,
    input  logic [nco_pkg::FRAC_W-1:0]          frac,
    input  logic                                negate,
    output logic signed [nco_pkg::VAL_W-1:0]    value
);

    localparam int PW = nco_pkg::FRAC_W + nco_pkg::VAL_W + 1;

    // stage 1: alongside the registered table read
    logic [nco_pkg::FRAC_W-1:0]        frac1_reg;
    logic                              neg1_reg;
    // stage 2: product
    logic signed [PW-1:0]              prod2_reg;
    logic signed [PW-1:0]              prod2_next;
    logic [nco_pkg::ROM_W-1:0]         a2_reg;
    logic                              neg2_reg;
    // output
    logic signed [nco_pkg::VAL_W-1:0]  value_reg;
    logic signed [nco_pkg::VAL_W-1:0]  value_next;

    logic signed [nco_pkg::VAL_W-1:0]  diff;
    logic signed [nco_pkg::VAL_W-1:0]  step;
    logic signed [nco_pkg::VAL_W-1:0]  mag;

    always_comb
    begin
        diff       = $signed({1'b0, rdata_b}) - $signed({1'b0, rdata_a});
        prod2_next = $signed({1'b0, frac1_reg}) * diff;
        // floor division by 2^16: take the bits above the fraction
        step       = prod2_reg[PW-2:nco_pkg::FRAC_W];
        mag        = $signed({1'b0, a2_reg}) + step;
        value_next = neg2_reg ? -mag : mag;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load1)
        begin
            frac1_reg <= frac;
            neg1_reg  <= negate;
        end
        if (ctrl.load2)
        begin
            prod2_reg <= prod2_next;
            a2_reg    <= rdata_a;
            neg2_reg  <= neg1_reg;
        end
        if (ctrl.load_out)
        begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule
